// ----- rtl/ucl_pkg.sv -----
`default_nettype none
package ucl_pkg;

    // Item and register field widths
    localparam int COLOR_W     = 24;
    localparam int COUNT_OUT_W = 9;
    localparam int PAL_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PALETTES = 1'd1;

    // Image-mode limit: palettes times colors per palette, plus the shared color
    localparam int PALETTE_COLORS = 15;
    localparam int SHARED_COLORS  = 1;

    // Register reset values
    localparam logic [PAL_W-1:0] MAX_PALETTES_RST = 5'd1;

endpackage
`default_nettype wire

// ----- rtl/ucl_ram.sv -----
`default_nettype none
module ucl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/unique_color_limit_checker.sv -----
`default_nettype none
// Distinct color counter with a limit. Each input item is one 24-bit RGB pixel; each
// gives exactly one result item with the distinct color count, the sticky over-limit
// flag and, in tile mode, a mark on the last pixel of each tile. The color set lives in
// one single-port-write, registered-read RAM of SET_DEPTH entries and is searched one
// entry per cycle. With N colors held before the pixel (zero after an image start, at
// most SET_DEPTH), a new color is compared with all N entries before it is inserted and
// reported, while a known color stops at its matching entry. A new item is taken only
// after the previous result has been placed in the output register; that result may
// still wait there for the downstream side, and while it waits the next item stalls
// before its final step. The RAM needs no clearing after reset: only entries below the
// current count are ever compared.
module unique_color_limit_checker #(
    parameter int TILE_SIDE        = 8,
    parameter int TILE_COLOR_LIMIT = 16,
    parameter int SET_DEPTH        = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration port
    input  wire logic                             cfg_we,
    input  wire logic [ucl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ucl_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [ucl_pkg::COLOR_W-1:0]      pixel_color,
    input  wire logic                             image_start,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [ucl_pkg::COUNT_OUT_W-1:0]  distinct_count,
    output logic                                  over_limit,
    output logic                                  tile_last
);

    import ucl_pkg::*;

    localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
    localparam int TIDX_W      = $clog2(TILE_PIXELS);
    localparam int AW          = $clog2(SET_DEPTH);
    localparam int CNT_W       = $clog2(SET_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]               state_reg,      state_next;
    logic [COLOR_W-1:0]       color_reg,      color_next;
    logic [CNT_W-1:0]         count_reg,      count_next;
    logic [CNT_W-1:0]         rd_idx_reg,     rd_idx_next;
    logic                     cmp_pend_reg,   cmp_pend_next;
    logic                     hit_reg,        hit_next;
    logic                     err_reg,        err_next;
    logic [TIDX_W-1:0]        tile_idx_reg,   tile_idx_next;
    logic                     tile_mode_reg,  tile_mode_next;
    logic [PAL_W-1:0]         max_pal_reg,    max_pal_next;
    logic                     out_valid_reg,  out_valid_next;
    logic [COUNT_OUT_W-1:0]   out_count_reg,  out_count_next;
    logic                     out_err_reg,    out_err_next;
    logic                     out_last_reg,   out_last_next;

    logic                     in_fire;
    logic                     finish_fire;
    logic                     hit_now;
    logic                     all_issued;
    logic [CMP_W-1:0]         image_limit;
    logic [CMP_W-1:0]         raw_limit;
    logic [CMP_W-1:0]         limit;
    logic                     room;
    logic                     ram_we;
    logic [COLOR_W-1:0]       ram_rdata;
    logic [CNT_W-1:0]         count_after;
    logic                     err_after;
    logic                     last_pix;

    // Color set storage
    ucl_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (SET_DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (color_reg),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Active limit, saturated to the store depth
    always_comb
    begin
        image_limit = CMP_W'(max_pal_reg) * CMP_W'(PALETTE_COLORS) + CMP_W'(SHARED_COLORS);
        raw_limit   = tile_mode_reg ? CMP_W'(TILE_COLOR_LIMIT) : image_limit;
        limit       = (raw_limit > CMP_W'(SET_DEPTH)) ? CMP_W'(SET_DEPTH) : raw_limit;
    end

    assign room        = CMP_W'(count_reg) < limit;
    assign in_fire     = in_valid && in_ready;
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign hit_now     = cmp_pend_reg && (ram_rdata == color_reg);
    assign all_issued  = rd_idx_reg == count_reg;
    assign ram_we      = finish_fire && !hit_reg && room;
    assign last_pix    = tile_mode_reg && (tile_idx_reg == TIDX_W'(TILE_PIXELS - 1));

    // Result of the insert decision
    always_comb
    begin
        count_after = count_reg;
        err_after   = err_reg;
        if (!hit_reg)
        begin
            if (room)
            begin
                count_after = count_reg + CNT_W'(1);
            end
            else
            begin
                err_after = 1'b1;
            end
        end
    end

    // Configuration writes
    always_comb
    begin
        tile_mode_next = tile_mode_reg;
        max_pal_next   = max_pal_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TILE_MODE:    tile_mode_next = cfg_data[0];
                CFG_MAX_PALETTES: max_pal_next   = cfg_data[PAL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer: accept, search one entry per cycle, then insert a new color if there is room and report
    always_comb
    begin
        state_next    = state_reg;
        color_next    = color_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_pend_next = cmp_pend_reg;
        hit_next      = hit_reg;
        err_next      = err_reg;
        tile_idx_next = tile_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    color_next    = pixel_color;
                    rd_idx_next   = '0;
                    cmp_pend_next = 1'b0;
                    state_next    = ST_SEARCH;
                    if (image_start)
                    begin
                        count_next    = '0;
                        tile_idx_next = '0;
                        err_next      = 1'b0;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit_now)
                begin
                    hit_next      = 1'b1;
                    cmp_pend_next = 1'b0;
                    state_next    = ST_FINISH;
                end
                else if (all_issued)
                begin
                    hit_next      = 1'b0;
                    cmp_pend_next = 1'b0;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    cmp_pend_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    err_next   = err_after;
                    count_next = count_after;
                    state_next = ST_IDLE;
                    if (tile_mode_reg)
                    begin
                        if (last_pix)
                        begin
                            tile_idx_next = '0;
                            count_next    = '0;
                        end
                        else
                        begin
                            tile_idx_next = tile_idx_reg + TIDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load on finish, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
            out_count_next = COUNT_OUT_W'(count_after);
            out_err_next   = err_after;
            out_last_next  = last_pix;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_pend_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            err_reg       <= 1'b0;
            tile_idx_reg  <= '0;
            tile_mode_reg <= 1'b0;
            max_pal_reg   <= MAX_PALETTES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_pend_reg  <= cmp_pend_next;
            hit_reg       <= hit_next;
            err_reg       <= err_next;
            tile_idx_reg  <= tile_idx_next;
            tile_mode_reg <= tile_mode_next;
            max_pal_reg   <= max_pal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        out_count_reg <= out_count_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready       = state_reg == ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign distinct_count = out_count_reg;
    assign over_limit     = out_err_reg;
    assign tile_last      = out_last_reg;

`ifndef SYNTH
    // The set never grows past the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SET_DEPTH))
        else $error("color count exceeds store depth");

    // An insert always has room below the limit
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CMP_W'(count_reg) < limit))
        else $error("insert past the active limit");

    // The sticky flag clears only on an image start
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(err_reg) |-> $past(in_valid && in_ready && image_start))
        else $error("over-limit flag cleared without image start");

    // A pending compare always belongs to an issued entry
    a_cmp_issued: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEARCH) && cmp_pend_reg) |-> (rd_idx_reg != '0))
        else $error("compare pending with no read issued");

    // A search ends in the cycle after the last entry is issued
    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEARCH) && all_issued) |=> (state_reg == ST_FINISH))
        else $error("search did not end after last entry");
`endif

endmodule
`default_nettype wire

// ----- tb/unique_color_limit_checker_test.sv -----
module unique_color_limit_checker_test;
    import ucl_pkg::*;

    localparam int TILE_SIDE   = 8;
    localparam int TILE_AREA   = TILE_SIDE * TILE_SIDE;
    localparam int TILE_LIMIT  = 16;
    localparam int SET_SIZE    = 256;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 300;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   over;
        logic                   last;
    } tally_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = CFG_TILE_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic [COLOR_W-1:0]     pixel_color    = '0;
    logic                   image_start    = 1'b0;
    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic [COUNT_OUT_W-1:0] distinct_count;
    logic                   over_limit;
    logic                   tile_last;

    // Predicted block state and register copies
    logic [COLOR_W-1:0] seen_colors [SET_SIZE];
    int unsigned        held_colors = 0;
    int unsigned        tile_pos    = 0;
    bit                 err_flag    = 1'b0;
    bit                 cfg_tile    = 1'b0;
    logic [PAL_W-1:0]   cfg_pal     = MAX_PALETTES_RST;

    tally_t expected_tallies [$];
    int     mismatches   = 0;
    int     results_seen = 0;
    int     quiet_cycles = 0;
    int     stall_left   = 0;
    bit     in_pace      = 1'b1;
    bit     out_pace     = 1'b1;

    unique_color_limit_checker #(
        .TILE_SIDE        (TILE_SIDE),
        .TILE_COLOR_LIMIT (TILE_LIMIT),
        .SET_DEPTH        (SET_SIZE)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_color    (pixel_color),
        .image_start    (image_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distinct_count (distinct_count),
        .over_limit     (over_limit),
        .tile_last      (tile_last)
    );

    always #5 clk = ~clk;

    // Pick an idle length: mostly none or short, a few long
    function automatic int pick_gap(input bit pace);
        int r;
        if (!pace)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned color_limit();
        int unsigned lim;
        if (cfg_tile)
        begin
            lim = TILE_LIMIT;
        end
        else
        begin
            lim = cfg_pal * PALETTE_COLORS + SHARED_COLORS;
        end
        if (lim > SET_SIZE)
        begin
            lim = SET_SIZE;
        end
        return lim;
    endfunction

    // Update the predicted color set for one pixel and queue the tally it yields
    function automatic void predict_pixel(input logic [COLOR_W-1:0] color, input logic start);
        tally_t      t;
        int unsigned lim;
        bit          found;
        if (start)
        begin
            held_colors = 0;
            tile_pos    = 0;
            err_flag    = 1'b0;
        end
        lim   = color_limit();
        found = 1'b0;
        for (int i = 0; i < held_colors && i < SET_SIZE; i++)
        begin
            if (seen_colors[i] == color)
            begin
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (held_colors < lim)
            begin
                seen_colors[held_colors] = color;
                held_colors++;
            end
            else
            begin
                err_flag = 1'b1;
            end
        end
        t.count = COUNT_OUT_W'(held_colors);
        t.over  = err_flag;
        t.last  = 1'b0;
        // Close the tile after its last pixel; the counter holds in image mode
        if (cfg_tile)
        begin
            if (tile_pos >= TILE_AREA - 1)
            begin
                t.last      = 1'b1;
                tile_pos    = 0;
                held_colors = 0;
            end
            else
            begin
                tile_pos++;
            end
        end
        expected_tallies.push_back(t);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Offer one pixel item and hold it until accepted
    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic start);
        int gap;
        gap = pick_gap(in_pace);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_color <= color;
        image_start <= start;
        do @(posedge clk); while (!in_ready);
        predict_pixel(color, start);
    endtask

    // Stop offering items and wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_tallies.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_TILE_MODE)
        begin
            cfg_tile = value[0];
        end
        else
        begin
            cfg_pal = value[PAL_W-1:0];
        end
    endtask

    // Write both registers once the block is idle
    task automatic configure(input bit tile, input logic [PAL_W-1:0] pal);
        drain();
        write_reg(CFG_TILE_MODE, CFG_DATA_W'(tile));
        write_reg(CFG_MAX_PALETTES, CFG_DATA_W'(pal));
    endtask

    // Start an image, send a pool of fresh colors, then repeats drawn from it
    task automatic fill_image(input int pool_size, input int extra);
        logic [COLOR_W-1:0] pool [$];
        for (int i = 0; i < pool_size; i++)
        begin
            pool.push_back(COLOR_W'($urandom));
        end
        for (int i = 0; i < pool_size; i++)
        begin
            send_pixel(pool[i], i == 0);
        end
        for (int i = 0; i < extra; i++)
        begin
            send_pixel(pool[$urandom_range(0, pool_size - 1)], 1'b0);
        end
    endtask

    // Defaults after reset: image mode with one palette
    task automatic test_reset_defaults();
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hAAAAAA, 1'b0);
        send_pixel(24'h555555, 1'b0);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h800000, 1'b0);
        send_pixel(24'h000001, 1'b0);
    endtask

    // Zero palettes leave room for a single color
    task automatic test_palette_zero();
        configure(1'b0, 5'd0);
        send_pixel(24'h123456, 1'b1);
        send_pixel(24'h654321, 1'b0);
        send_pixel(24'h123456, 1'b0);
        send_pixel(24'hFFFFFF, 1'b1);
    endtask

    // Image mode limits up to and past the store depth
    task automatic test_image_limits();
        configure(1'b0, 5'd1);
        fill_image(17, 6);
        in_pace  = 1'b0;
        out_pace = 1'b0;
        configure(1'b0, 5'd2);
        fill_image(30, 8);
        in_pace  = 1'b1;
        out_pace = 1'b1;
        configure(1'b0, 5'd16);
        fill_image(242, 10);
        configure(1'b0, 5'd31);
        fill_image(258, 10);
    endtask

    // Tiles of 64 pixels, each drawing on a pool of 1 to 24 colors
    task automatic test_tile_sequences();
        logic [COLOR_W-1:0] pool [$];
        int                 pool_size;
        int                 cut_at;
        configure(1'b1, PAL_W'($urandom_range(0, 31)));
        for (int tile = 0; tile < 5; tile++)
        begin
            pool.delete();
            pool_size = $urandom_range(1, 24);
            for (int i = 0; i < pool_size; i++)
            begin
                pool.push_back(COLOR_W'($urandom));
            end
            // Break the tile order now and then with a restart mid-tile
            cut_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, TILE_AREA - 1) : -1;
            for (int p = 0; p < TILE_AREA; p++)
            begin
                send_pixel(pool[$urandom_range(0, pool_size - 1)],
                           (tile == 0 && p == 0) || p == cut_at);
            end
        end
    endtask

    // Shrink the limit under a fuller set, then switch to tiles without a restart
    task automatic test_count_above_limit();
        logic [COLOR_W-1:0] pool [$];
        configure(1'b0, 5'd3);
        for (int i = 0; i < 40; i++)
        begin
            pool.push_back(COLOR_W'($urandom));
        end
        for (int i = 0; i < 40; i++)
        begin
            send_pixel(pool[i], i == 0);
        end
        configure(1'b0, 5'd1);
        send_pixel(pool[3], 1'b0);
        send_pixel(pool[39], 1'b0);
        send_pixel(pool[0], 1'b0);
        send_pixel(COLOR_W'($urandom), 1'b0);
        send_pixel(pool[17], 1'b0);
        configure(1'b1, 5'd1);
        send_pixel(pool[5], 1'b0);
        send_pixel(pool[25], 1'b0);
        send_pixel(COLOR_W'($urandom), 1'b0);
        // Run the tile out; the error flag must survive the tile end
        while (tile_pos != 0)
        begin
            send_pixel(pool[$urandom_range(0, 39)], 1'b0);
        end
        send_pixel(pool[1], 1'b0);
    endtask

    // The tile position holds while pixels go through in image mode
    task automatic test_tile_counter_hold();
        logic [COLOR_W-1:0] pool [4];
        for (int i = 0; i < 4; i++)
        begin
            pool[i] = COLOR_W'($urandom);
        end
        configure(1'b1, 5'd16);
        for (int i = 0; i < 10; i++)
        begin
            send_pixel(pool[$urandom_range(0, 3)], i == 0);
        end
        configure(1'b0, 5'd16);
        for (int i = 0; i < 5; i++)
        begin
            send_pixel(pool[$urandom_range(0, 3)], 1'b0);
        end
        configure(1'b1, 5'd16);
        do
        begin
            send_pixel(pool[$urandom_range(0, 3)], 1'b0);
        end
        while (tile_pos != 0);
    endtask

    // Short phases with random settings, pacing and restarts
    task automatic test_random_mix();
        logic [COLOR_W-1:0] pool [$];
        int                 pool_size;
        int                 count;
        logic [PAL_W-1:0]   pal;
        for (int phase = 0; phase < 8; phase++)
        begin
            in_pace  = $urandom_range(0, 3) != 0;
            out_pace = $urandom_range(0, 3) != 0;
            pal      = ($urandom_range(0, 9) < 7) ? PAL_W'($urandom_range(0, 4))
                                                  : PAL_W'($urandom_range(0, 31));
            configure(1'($urandom_range(0, 1)), pal);
            pool.delete();
            pool_size = $urandom_range(1, 20);
            for (int i = 0; i < pool_size; i++)
            begin
                pool.push_back(COLOR_W'($urandom));
            end
            count = $urandom_range(8, 20);
            for (int i = 0; i < count; i++)
            begin
                send_pixel(pool[$urandom_range(0, pool_size - 1)],
                           (i == 0) ? 1'($urandom_range(0, 1))
                                    : ($urandom_range(0, 15) == 0));
            end
        end
    endtask

    // Drive the output ready and check each accepted result against the oldest tally
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    report_mismatch("result with no pending pixel", int'(distinct_count), -1);
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (distinct_count !== want.count)
                    begin
                        report_mismatch("distinct_count", int'(distinct_count),
                                        int'(want.count));
                    end
                    if (over_limit !== want.over)
                    begin
                        report_mismatch("over_limit", int'(over_limit), int'(want.over));
                    end
                    if (tile_last !== want.last)
                    begin
                        report_mismatch("tile_last", int'(tile_last), int'(want.last));
                    end
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(out_pace);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_palette_zero();
        test_image_limits();
        test_tile_sequences();
        test_count_above_limit();
        test_tile_counter_hold();
        test_random_mix();
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ucl_pkg.sv
rtl/ucl_ram.sv
rtl/unique_color_limit_checker.sv
tb/unique_color_limit_checker_test.sv
